FILE: rtl/bsaf_pkg.sv
`timescale 1ns / 1ps
// Package for the barrel shifter and adder flags block.
// Holds the shared widths, operation and shift codes, and the payload types.
// Depends on nothing; every other file in rtl uses it.
package bsaf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AmtW  = 8;
  localparam int unsigned KindW = 2;
  // Number of amount bits that select a position inside one word.
  localparam int unsigned PosW  = $clog2(WordW);

  localparam logic [AmtW-1:0] AmtWord = AmtW'(WordW);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SHIFT = 1'b1
  } op_t;

  typedef enum logic [KindW-1:0] {
    SHIFT_LSL = 2'b00,
    SHIFT_LSR = 2'b01,
    SHIFT_ASR = 2'b10,
    SHIFT_ROR = 2'b11
  } shift_kind_t;

  typedef struct packed {
    op_t               op;
    logic [WordW-1:0]  operand_a;
    logic [WordW-1:0]  operand_b;
    logic [AmtW-1:0]   shift_amount;
    shift_kind_t       shift_type;
  } operands_t;

  typedef struct packed {
    logic [WordW-1:0]  result;
    logic              carry_out;
    logic              overflow;
  } results_t;

  typedef struct packed {
    logic [WordW-1:0]  result;
    logic              carry_out;
  } shift_out_t;

endpackage

FILE: rtl/bsaf_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the barrel shifter and adder flags block.
// One interface for operand transfers, one for result transfers.
// Depends on bsaf_pkg for the field widths.

interface bsaf_operands_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bsaf_pkg::WordW-1:0]    operand_a;
  logic [bsaf_pkg::WordW-1:0]    operand_b;
  logic [bsaf_pkg::AmtW-1:0]     shift_amount;
  logic [bsaf_pkg::KindW-1:0]    shift_type;

  modport source (output valid, output op, output operand_a, output operand_b,
                  output shift_amount, output shift_type, input ready);
  modport sink   (input valid, input op, input operand_a, input operand_b,
                  input shift_amount, input shift_type, output ready);
endinterface

interface bsaf_results_if;
  logic                          valid;
  logic                          ready;
  logic [bsaf_pkg::WordW-1:0]    result;
  logic                          carry_out;
  logic                          overflow;

  modport source (output valid, output result, output carry_out, output overflow,
                  input ready);
  modport sink   (input valid, input result, input carry_out, input overflow,
                  output ready);
endinterface

FILE: rtl/bsaf_adder.sv
`timescale 1ns / 1ps
// 32-bit adder with carry out and signed overflow flag.
// Depends on bsaf_pkg for widths and the result type.
module bsaf_adder (
  input  logic [bsaf_pkg::WordW-1:0] operand_a,
  input  logic [bsaf_pkg::WordW-1:0] operand_b,
  output bsaf_pkg::results_t         sum
);

  logic [bsaf_pkg::WordW:0] total;

  assign total = {1'b0, operand_a} + {1'b0, operand_b};

  always_comb begin
    sum.result    = total[bsaf_pkg::WordW-1:0];
    sum.carry_out = total[bsaf_pkg::WordW];
    // Overflow when both operands share a sign that the sum does not.
    sum.overflow  = (operand_a[bsaf_pkg::WordW-1] == operand_b[bsaf_pkg::WordW-1]) &&
                    (operand_a[bsaf_pkg::WordW-1] != total[bsaf_pkg::WordW-1]);
  end

endmodule

FILE: rtl/bsaf_shifter.sv
`timescale 1ns / 1ps
// Barrel shifter with shifter carry and the large-amount rules.
// Depends on bsaf_pkg for widths, shift codes and the shifter output type.
module bsaf_shifter (
  input  logic [bsaf_pkg::WordW-1:0] value,
  input  logic [bsaf_pkg::AmtW-1:0]  shift_amount,
  input  bsaf_pkg::shift_kind_t      shift_type,
  input  logic                       held_carry,
  output bsaf_pkg::shift_out_t       shifted
);

  localparam int unsigned W = bsaf_pkg::WordW;

  logic [bsaf_pkg::PosW-1:0] pos;
  logic [2*W-1:0]            lsl_wide;
  logic [2*W-1:0]            lsr_wide;
  logic [2*W-1:0]            asr_wide;
  logic [2*W-1:0]            ror_wide;
  logic                      sign;
  logic                      amt_zero;
  logic                      amt_word;
  logic                      amt_below;

  assign pos       = shift_amount[bsaf_pkg::PosW-1:0];
  assign sign      = value[W-1];
  assign amt_zero  = (shift_amount == '0);
  assign amt_word  = (shift_amount == bsaf_pkg::AmtWord);
  assign amt_below = (shift_amount < bsaf_pkg::AmtWord);

  // Carry is the bit past the kept word, or the kept word's top bit for ROR.
  assign lsl_wide = {{W{1'b0}}, value} << pos;
  assign lsr_wide = {value, {W{1'b0}}} >> pos;
  assign asr_wide = $signed({value, {W{1'b0}}}) >>> pos;
  assign ror_wide = {value, value} >> pos;

  always_comb begin
    shifted.result    = value;
    shifted.carry_out = held_carry;
    if (!amt_zero) begin
      unique case (shift_type)
        bsaf_pkg::SHIFT_LSL: begin
          shifted.result    = amt_below ? lsl_wide[W-1:0] : '0;
          shifted.carry_out = amt_below ? lsl_wide[W] : (amt_word & value[0]);
        end
        bsaf_pkg::SHIFT_LSR: begin
          shifted.result    = amt_below ? lsr_wide[2*W-1:W] : '0;
          shifted.carry_out = amt_below ? lsr_wide[W-1] : (amt_word & sign);
        end
        bsaf_pkg::SHIFT_ASR: begin
          shifted.result    = amt_below ? asr_wide[2*W-1:W] : {W{sign}};
          shifted.carry_out = amt_below ? asr_wide[W-1] : sign;
        end
        bsaf_pkg::SHIFT_ROR: begin
          // A rotate by a multiple of the word width leaves the value as it is.
          shifted.result    = ror_wide[W-1:0];
          shifted.carry_out = ror_wide[W-1];
        end
        default: begin
          shifted.result    = value;
          shifted.carry_out = held_carry;
        end
      endcase
    end
  end

endmodule

FILE: rtl/barrel_shifter_and_adder_flags_core.sv
`timescale 1ns / 1ps
// Top level of the barrel shifter and adder flags block: ALU front of a 32-bit core.
// Depends on bsaf_pkg, the channel interfaces in bsaf_if, bsaf_adder and bsaf_shifter.
//
//   Channel    Direction  Carries
//   --------   ---------  ----------------------------------------------------
//   operands   in         op, operand_a, operand_b, shift_amount, shift_type
//   results    out        result, carry_out, overflow (one per operand transfer)
//
// Each operand transfer yields one result transfer, held first in the input register
// and then in the result register.
// One transfer is taken every cycle while results is not stalled; the rate is set by
// the single adder and shifter pass between the two registers.
// Reset (rst, synchronous, active high) empties both registers and clears the held
// shifter carry.
// A stall on results holds the result register; the input register still takes a
// transfer while it is empty, so the block backs up only when both are full.

module barrel_shifter_and_adder_flags_core (
  input  logic                   clk,
  input  logic                   rst,
  bsaf_operands_if.sink          operands,
  bsaf_results_if.source         results
);

  // Input register.
  logic                  in_valid;
  bsaf_pkg::operands_t   in_data;

  // Result register.
  logic                  out_valid;
  bsaf_pkg::results_t    out_data;

  // Carry left by the last shift with a nonzero amount.
  logic                  held_shift_carry;
  logic                  held_shift_carry_next;

  bsaf_pkg::results_t    add_res;
  bsaf_pkg::shift_out_t  shift_res;
  bsaf_pkg::results_t    alu_res;

  logic                  out_free;
  logic                  advance;

  // The result register can take a new value when empty or being emptied this cycle.
  assign out_free = !out_valid || results.ready;
  assign advance  = in_valid && out_free;

  assign operands.ready = !in_valid || out_free;

  bsaf_adder u_adder (
    .operand_a (in_data.operand_a),
    .operand_b (in_data.operand_b),
    .sum       (add_res)
  );

  bsaf_shifter u_shifter (
    .value        (in_data.operand_a),
    .shift_amount (in_data.shift_amount),
    .shift_type   (in_data.shift_type),
    .held_carry   (held_shift_carry),
    .shifted      (shift_res)
  );

  // Items leave the input register in order, so the held carry seen here always
  // reflects every earlier shift.
  always_comb begin
    held_shift_carry_next = held_shift_carry;
    unique case (in_data.op)
      bsaf_pkg::OP_ADD: begin
        alu_res = add_res;
      end
      bsaf_pkg::OP_SHIFT: begin
        alu_res.result    = shift_res.result;
        alu_res.carry_out = shift_res.carry_out;
        alu_res.overflow  = 1'b0;
        held_shift_carry_next = shift_res.carry_out;
      end
      default: begin
        alu_res = add_res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      held_shift_carry <= 1'b0;
    end else begin
      if (operands.valid && operands.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid        <= 1'b1;
        held_shift_carry <= held_shift_carry_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (operands.valid && operands.ready) begin
      in_data.op           <= bsaf_pkg::op_t'(operands.op);
      in_data.operand_a    <= operands.operand_a;
      in_data.operand_b    <= operands.operand_b;
      in_data.shift_amount <= operands.shift_amount;
      in_data.shift_type   <= bsaf_pkg::shift_kind_t'(operands.shift_type);
    end
    if (advance) begin
      out_data <= alu_res;
    end
  end

  assign results.valid     = out_valid;
  assign results.result    = out_data.result;
  assign results.carry_out = out_data.carry_out;
  assign results.overflow  = out_data.overflow;

endmodule
